// ----- sv/sin_cos_table_interpolator_defines.svh -----
// Assertion macros used by the checker file of the sine/cosine interpolator.
`ifndef SIN_COS_TABLE_INTERPOLATOR_DEFINES_SVH
`define SIN_COS_TABLE_INTERPOLATOR_DEFINES_SVH

// Check outside reset.
`define SCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every edge, reset included.
`define SCT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/sct_pkg.sv -----
// Constants, types and the quarter-wave sine table of the sine/cosine interpolator.
`timescale 1ns / 1ps
package sct_pkg;

   localparam int ANGLE_FRAC_BITS = 8;
   localparam int TABLE_ENTRIES   = 361;
   localparam int OUT_SCALE_BITS  = 15;

   localparam int ANGLE_W = 24;
   localparam int VALUE_W = 16;
   localparam int ENTRY_W = OUT_SCALE_BITS + 1;

   localparam int FULL_TURN          = TABLE_ENTRIES - 1;
   localparam int HALF_TURN          = 180;
   localparam int QUARTER_TURN       = HALF_TURN / 2;
   localparam int THREE_QUARTER_TURN = HALF_TURN + QUARTER_TURN;

   localparam int DEG_W  = $clog2(FULL_TURN + QUARTER_TURN + 1);
   localparam int QIDX_W = $clog2(QUARTER_TURN + 1);

   // Biased whole degree: offset is a multiple of a full turn that covers the signed range.
   localparam int RED_W = ANGLE_W + 1;
   localparam logic [RED_W-1:0] RED_OFFSET =
      RED_W'(((1 << (ANGLE_W - 1)) + FULL_TURN - 1) / FULL_TURN * FULL_TURN);
   // Reciprocal of a full turn, rounded up.
   localparam int RECIP_SHIFT = 33;
   localparam logic [RED_W-1:0] RECIP_M =
      RED_W'(((64'd1 << RECIP_SHIFT) + 64'(FULL_TURN) - 64'd1) / 64'(FULL_TURN));
   localparam int QUOT_W = RED_W - 8;

   typedef enum logic {
      CMD_SIN = 1'b0,
      CMD_COS = 1'b1
   } cmd_type;

   typedef logic signed [ENTRY_W-1:0] entry_type;

   localparam logic [OUT_SCALE_BITS-1:0] QUARTER_SIN [0:QUARTER_TURN] = '{
      15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
      15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
      15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
      15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14364, 15'd14876,
      15'd15383, 15'd15886, 15'd16384, 15'd16876, 15'd17364, 15'd17846, 15'd18323,
      15'd18794, 15'd19260, 15'd19720, 15'd20173, 15'd20621, 15'd21062, 15'd21497,
      15'd21925, 15'd22347, 15'd22762, 15'd23170, 15'd23571, 15'd23964, 15'd24351,
      15'd24730, 15'd25101, 15'd25465, 15'd25821, 15'd26169, 15'd26509, 15'd26841,
      15'd27165, 15'd27481, 15'd27788, 15'd28087, 15'd28377, 15'd28659, 15'd28932,
      15'd29196, 15'd29451, 15'd29697, 15'd29934, 15'd30162, 15'd30381, 15'd30591,
      15'd30791, 15'd30982, 15'd31163, 15'd31335, 15'd31498, 15'd31650, 15'd31794,
      15'd31927, 15'd32051, 15'd32165, 15'd32269, 15'd32364, 15'd32448, 15'd32523,
      15'd32587, 15'd32642, 15'd32687, 15'd32722, 15'd32747, 15'd32762, 15'd32767
   };

   // Sine of a whole degree in [0, 360), folded onto the quarter table.
   function automatic entry_type sin_deg(input logic [DEG_W-1:0] idx);
      logic [DEG_W-1:0] k;
      logic             neg;
      entry_type        mag;
      if (idx <= DEG_W'(QUARTER_TURN)) begin
         k   = idx;
         neg = 1'b0;
      end else if (idx <= DEG_W'(HALF_TURN)) begin
         k   = DEG_W'(HALF_TURN) - idx;
         neg = 1'b0;
      end else if (idx <= DEG_W'(THREE_QUARTER_TURN)) begin
         k   = idx - DEG_W'(HALF_TURN);
         neg = 1'b1;
      end else begin
         k   = DEG_W'(FULL_TURN) - idx;
         neg = 1'b1;
      end
      mag = ENTRY_W'(QUARTER_SIN[k[QIDX_W-1:0]]);
      return neg ? -mag : mag;
   endfunction

endpackage

// ----- sv/sct_if.sv -----
// Request and response channel interfaces of the sine/cosine interpolator.
`timescale 1ns / 1ps
interface sct_req_if import sct_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic signed [ANGLE_W-1:0] angle;

   modport source (output valid, output command, output angle, input ready);
   modport sink   (input valid, input command, input angle, output ready);
endinterface

interface sct_rsp_if import sct_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ----- sv/sct_reduce.sv -----
// Range reduction stage: whole degree biased and divided by a full turn, fraction split off.
`timescale 1ns / 1ps
module sct_reduce import sct_pkg::*; #(
   parameter int FRAC_BITS = ANGLE_FRAC_BITS,
   parameter int FRAC_W    = (FRAC_BITS > 0) ? FRAC_BITS : 1
) (
   input  logic                      clock,
   input  logic                      en,
   input  cmd_type                   cmd,
   input  logic signed [ANGLE_W-1:0] angle,
   output cmd_type                   cmd_ff,
   output logic [FRAC_W-1:0]         frac_ff,
   output logic [RED_W-1:0]          biased_ff,
   output logic [QUOT_W-1:0]         quot_ff
);

   logic signed [ANGLE_W-1:0] whole;
   logic [RED_W-1:0]          biased_in;
   logic [2*RED_W-1:0]        prod;
   logic [QUOT_W-1:0]         quot_in;
   logic [FRAC_W-1:0]         frac_in;

   always_comb begin
      whole     = angle >>> FRAC_BITS;
      biased_in = RED_W'(whole) + RED_OFFSET;
      prod      = (2*RED_W)'(biased_in) * (2*RED_W)'(RECIP_M);
      quot_in   = prod[RECIP_SHIFT +: QUOT_W];
      frac_in   = (FRAC_BITS > 0) ? angle[FRAC_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd_ff    <= cmd;
         frac_ff   <= frac_in;
         biased_ff <= biased_in;
         quot_ff   <= quot_in;
      end
   end

endmodule

// ----- sv/sct_lookup.sv -----
// Lookup stage: remainder in degrees, sine or cosine entries at the degree and the next one.
`timescale 1ns / 1ps
module sct_lookup import sct_pkg::*; #(
   parameter int FRAC_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  cmd_type           cmd,
   input  logic [FRAC_W-1:0] frac,
   input  logic [RED_W-1:0]  biased,
   input  logic [QUOT_W-1:0] quot,
   output entry_type         lo_ff,
   output entry_type         hi_ff,
   output logic [FRAC_W-1:0] frac_ff
);

   logic [RED_W-1:0] rem;
   logic [DEG_W-1:0] deg;
   logic [DEG_W-1:0] base;
   logic [DEG_W-1:0] base_next;
   logic [DEG_W-1:0] idx_lo;
   logic [DEG_W-1:0] idx_hi;

   always_comb begin
      rem       = biased - RED_W'(quot) * RED_W'(FULL_TURN);
      deg       = rem[DEG_W-1:0];
      base      = deg + ((cmd == CMD_COS) ? DEG_W'(QUARTER_TURN) : '0);
      base_next = base + DEG_W'(1);
      idx_lo    = (base >= DEG_W'(FULL_TURN)) ? base - DEG_W'(FULL_TURN) : base;
      idx_hi    = (base_next >= DEG_W'(FULL_TURN)) ? base_next - DEG_W'(FULL_TURN)
                                                   : base_next;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= sin_deg(idx_lo);
         hi_ff   <= sin_deg(idx_hi);
         frac_ff <= frac;
      end
   end

endmodule

// ----- sv/sct_interp.sv -----
// Interpolation stage: entry plus fraction times slope, floored, into the result register.
`timescale 1ns / 1ps
module sct_interp import sct_pkg::*; #(
   parameter int FRAC_BITS = ANGLE_FRAC_BITS,
   parameter int FRAC_W    = (FRAC_BITS > 0) ? FRAC_BITS : 1
) (
   input  logic                      clock,
   input  logic                      en,
   input  entry_type                 lo,
   input  entry_type                 hi,
   input  logic [FRAC_W-1:0]         frac,
   output logic signed [VALUE_W-1:0] value_ff
);

   localparam int PROD_W = FRAC_W + ENTRY_W + 2;
   localparam int SUM_W  = ENTRY_W + 2;

   logic signed [ENTRY_W:0]   slope;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  step;
   logic [SUM_W-1:0]          sum;

   always_comb begin
      slope = (ENTRY_W+1)'(hi) - (ENTRY_W+1)'(lo);
      prod  = $signed({1'b0, frac}) * slope;
      step  = prod >>> FRAC_BITS;
      sum   = SUM_W'(lo) + step[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= sum[VALUE_W-1:0];
      end
   end

endmodule

// ----- sv/sin_cos_table_interpolator.sv -----
// Sine/cosine of a fixed-point angle in degrees by table lookup and linear interpolation.
//
// Request channel (req_ch): command selects sine or cosine, angle is a signed degree
// value with FRAC_BITS fraction bits. Response channel (rsp_ch): value is the result
// scaled by 32767. Both channels move a transaction when valid and ready are high.
// Every request yields exactly one response, in order.
//
// Four register stages: input register, range reduction (multiply by the reciprocal
// of a full turn), table lookup, interpolation into the result register. One
// transaction per cycle is sustained while rsp_ch.ready is held high; the reciprocal
// multiply and the slope multiply each own a stage.
//
// Every stage holds when the stage after it is full and stalled, so a stalled
// receiver fills the pipeline and req_ch.ready drops only once all stages are full.
// Reset clears all stage valid bits; the table is constant, so no clearing is needed.
`timescale 1ns / 1ps
module sin_cos_table_interpolator import sct_pkg::*; #(
   parameter int FRAC_BITS = ANGLE_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   sct_req_if.sink    req_ch,
   sct_rsp_if.source  rsp_ch
);

   localparam int FRAC_W = (FRAC_BITS > 0) ? FRAC_BITS : 1;

   logic                      in_valid_ff, in_valid_in;
   logic                      red_valid_ff, red_valid_in;
   logic                      lkp_valid_ff, lkp_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      in_rdy, red_rdy, lkp_rdy, rsp_rdy;
   cmd_type                   cmd_ff;
   logic signed [ANGLE_W-1:0] angle_ff;

   cmd_type                   red_cmd;
   logic [FRAC_W-1:0]         red_frac;
   logic [RED_W-1:0]          red_biased;
   logic [QUOT_W-1:0]         red_quot;
   entry_type                 lkp_lo, lkp_hi;
   logic [FRAC_W-1:0]         lkp_frac;
   logic signed [VALUE_W-1:0] value;

   always_comb begin
      rsp_rdy      = !rsp_valid_ff || rsp_ch.ready;
      lkp_rdy      = !lkp_valid_ff || rsp_rdy;
      red_rdy      = !red_valid_ff || lkp_rdy;
      in_rdy       = !in_valid_ff || red_rdy;
      in_valid_in  = in_rdy  ? req_ch.valid : in_valid_ff;
      red_valid_in = red_rdy ? in_valid_ff  : red_valid_ff;
      lkp_valid_in = lkp_rdy ? red_valid_ff : lkp_valid_ff;
      rsp_valid_in = rsp_rdy ? lkp_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         red_valid_ff <= 1'b0;
         lkp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         red_valid_ff <= red_valid_in;
         lkp_valid_ff <= lkp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy) begin
         cmd_ff   <= cmd_type'(req_ch.command);
         angle_ff <= req_ch.angle;
      end
   end

   sct_reduce #(
      .FRAC_BITS (FRAC_BITS),
      .FRAC_W    (FRAC_W)
   ) u_reduce (
      .clock     (clock),
      .en        (red_rdy),
      .cmd       (cmd_ff),
      .angle     (angle_ff),
      .cmd_ff    (red_cmd),
      .frac_ff   (red_frac),
      .biased_ff (red_biased),
      .quot_ff   (red_quot)
   );

   sct_lookup #(
      .FRAC_W  (FRAC_W)
   ) u_lookup (
      .clock   (clock),
      .en      (lkp_rdy),
      .cmd     (red_cmd),
      .frac    (red_frac),
      .biased  (red_biased),
      .quot    (red_quot),
      .lo_ff   (lkp_lo),
      .hi_ff   (lkp_hi),
      .frac_ff (lkp_frac)
   );

   sct_interp #(
      .FRAC_BITS (FRAC_BITS),
      .FRAC_W    (FRAC_W)
   ) u_interp (
      .clock    (clock),
      .en       (rsp_rdy),
      .lo       (lkp_lo),
      .hi       (lkp_hi),
      .frac     (lkp_frac),
      .value_ff (value)
   );

   assign req_ch.ready = in_rdy;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value = value;

endmodule

// ----- sv/sct_checker.sv -----
// Port checker of the sine/cosine interpolator and its bind to the top level.
`timescale 1ns / 1ps
`include "sin_cos_table_interpolator_defines.svh"
module sct_checker import sct_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_value
);

   `SCT_ASSERT_ALWAYS(a_rsp_idle_after_reset, reset |=> !rsp_valid, "response valid after reset")
   `SCT_ASSERT(a_ready_when_drained, rsp_ready |-> req_ready, "request stalled while response side drains")
   `SCT_ASSERT(a_value_in_range, rsp_valid |-> (rsp_value != {1'b1, {(VALUE_W-1){1'b0}}}), "response value out of range")
   `SCT_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)), "stalled response changed")

endmodule

bind sin_cos_table_interpolator sct_checker u_sct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_value (rsp_ch.value)
);
